/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, types and pointer arithmetic for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int FILL_W      = $clog2(DEPTH + 1);

    // Fixed widths of the stream fields.
    localparam int KIND_W      = 3;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_OUT_W  = 7;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - FILL_OUT_W - WORD_W;

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam fill_t FULL_FILL = fill_t'(DEPTH);
    localparam ptr_t  LAST_SLOT = ptr_t'(DEPTH - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_CLEAR      = 3'd4,
        KIND_DUMP       = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } state_t;

    // Physical slot of the element that sits offset places behind the front.
    function automatic ptr_t slot_of(ptr_t front, fill_t offset);
        logic [FILL_W:0] sum;
        sum = (FILL_W + 1)'(front) + (FILL_W + 1)'(offset);
        if (sum >= (FILL_W + 1)'(DEPTH))
        begin
            sum = sum - (FILL_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

/* rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. The read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bounded_double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core
// Bounded double-ended queue of data words kept in a circular buffer.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation in s_tuser (push front, push back,
// pop front, pop back, clear, dump) and the word to push in s_tdata. Every
// operation answers with one output transfer, except a dump of a non-empty
// queue, which sends all held elements front to back with m_tlast on the
// final one. Elements live in a single RAM with one write and one registered
// read port; the front pointer and the fill count are in flip-flops. Pushes,
// clear, failed operations and the unused kind codes are answered straight
// from the idle state. A successful pop reads the RAM and waits in S_POP until
// the output register is free. A dump streams one element per cycle from the
// read port while the output is not stalled. The output register lets a new
// item be taken in the same cycle as the previous result is being transferred.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bdq_pkg::KIND_W-1:0]       s_tuser,  // kind
    input  logic [bdq_pkg::WORD_W-1:0]       s_tdata,  // data_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bdq_pkg::STATUS_W-1:0]     m_tuser,  // status
    output logic [bdq_pkg::OUT_TDATA_W-1:0]  m_tdata,  // data_out, fill, zero pad
    output logic                             m_tlast
);

    import bdq_pkg::*;

    state_t  state_reg, state_next;
    ptr_t    front_reg, front_next;
    fill_t   fill_reg, fill_next;
    fill_t   idx_reg, idx_next;
    logic    rd_pending_reg, rd_pending_next;

    logic    out_valid_reg;
    status_t out_status_reg;
    logic [WORD_W-1:0]     out_data_reg;
    logic [FILL_OUT_W-1:0] out_fill_reg;
    logic    out_last_reg;

    logic    out_free;
    logic    consume;
    logic    issue;
    kind_t   kind;

    logic    load;
    status_t ld_status;
    logic [WORD_W-1:0] ld_data;
    fill_t   ld_fill;
    logic    ld_last;

    logic    ram_we;
    ptr_t    ram_waddr;
    word_t   ram_wdata;
    logic    ram_re;
    ptr_t    ram_raddr;
    word_t   ram_rdata;

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign kind     = kind_t'(s_tuser);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_fill_reg, out_data_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        rd_pending_next = rd_pending_reg;

        ram_we    = 1'b0;
        ram_waddr = front_reg;
        ram_wdata = word_t'(s_tdata);
        ram_re    = 1'b0;
        ram_raddr = front_reg;

        load      = 1'b0;
        ld_status = STAT_OK;
        ld_data   = '0;
        ld_fill   = fill_reg;
        ld_last   = 1'b1;

        consume   = 1'b0;
        issue     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            load = 1'b1;
                            if (fill_reg == FULL_FILL)
                            begin
                                ld_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (kind == KIND_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? LAST_SLOT
                                                                   : front_reg - 1'b1;
                                    ram_waddr  = front_next;
                                end
                                else
                                begin
                                    ram_waddr = slot_of(front_reg, fill_reg);
                                end
                                fill_next = fill_reg + 1'b1;
                                ld_fill   = fill_next;
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK:
                        begin
                            if (fill_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                                if (kind == KIND_POP_FRONT)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = slot_of(front_reg, fill_t'(1));
                                end
                                else
                                begin
                                    ram_raddr = slot_of(front_reg, fill_reg - 1'b1);
                                end
                                fill_next  = fill_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            fill_next  = '0;
                            front_next = '0;
                            load       = 1'b1;
                            ld_fill    = '0;
                        end
                        KIND_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                load      = 1'b1;
                                ld_status = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next        = '0;
                                rd_pending_next = 1'b0;
                                state_next      = S_DUMP;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // The RAM holds the popped word until the output register is free.
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_data    = WORD_W'(ram_rdata);
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // A new read may be issued whenever the word already read is
                // either absent or moving into the output register this cycle.
                consume = rd_pending_reg && out_free;
                issue   = (idx_reg != fill_reg) && (!rd_pending_reg || out_free);
                if (consume)
                begin
                    load    = 1'b1;
                    ld_data = WORD_W'(ram_rdata);
                    ld_last = (idx_reg == fill_reg);
                    if (ld_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(front_reg, idx_reg);
                    idx_next  = idx_reg + 1'b1;
                end
                rd_pending_next = issue || (rd_pending_reg && !out_free);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            rd_pending_reg <= rd_pending_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= ld_status;
            out_data_reg   <= ld_data;
            out_fill_reg   <= FILL_OUT_W'(ld_fill);
            out_last_reg   <= ld_last;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_FILL)
        else $error("fill count exceeds the queue depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= LAST_SLOT)
        else $error("front pointer outside the buffer");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rd_pending_reg)
        else $error("dump read still pending after returning to idle");

    a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (idx_reg <= fill_reg))
        else $error("dump index ran past the fill count");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && fill_reg == FULL_FILL
         && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK))
        |=> (fill_reg == FULL_FILL && $stable(front_reg)))
        else $error("push into a full queue changed its state");

endmodule
